// ===== design/nrbf_pkg.sv =====
package nrbf_pkg;

	localparam int GRID_0_DEF    = 8;
	localparam int GRID_1_DEF    = 8;
	localparam int OUT_DIMS_DEF  = 2;
	localparam int EXP_DEPTH_DEF = 1024;

	// shared multiplier: signed operands, wide enough for 33-bit unsigned values
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;

	// center position and point-to-center distance, signed Q8.8 with grid headroom
	localparam int CEN_W = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// exponent argument limit: q >= 2^29 (Q24.24) means the feature underflows
	localparam logic [29:0] Q_LIMIT = 30'h2000_0000;

	typedef enum logic [1:0] {
		ACT_EVAL      = 2'd0,
		ACT_UPDATE    = 2'd1,
		ACT_CLR_ALL   = 2'd2,
		ACT_CLR_TRACE = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_0       = 3'd0,
		REG_LOW_1       = 3'd1,
		REG_STEP_0      = 3'd2,
		REG_STEP_1      = 3'd3,
		REG_INV_VAR_0   = 3'd4,
		REG_INV_VAR_1   = 3'd5,
		REG_LEARN_RATE  = 3'd6,
		REG_TRACE_DECAY = 3'd7
	} cfg_reg_t;

	// |d| clamped to 15 bits; anything past 32767 squares beyond the limit anyway
	function automatic logic [14:0] mag15(input logic signed [CEN_W-1:0] d);
		logic [CEN_W-1:0] m;
		m = d[CEN_W-1] ? CEN_W'(-d) : CEN_W'(d);
		return (m > CEN_W'(32767)) ? 15'h7FFF : m[14:0];
	endfunction

	function automatic logic [29:0] clamp_q(input logic signed [PROD_W-1:0] p);
		return (p >= $signed({{(PROD_W-30){1'b0}}, Q_LIMIT})) ? Q_LIMIT : p[29:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-32:0] hi;
		hi = v[PROD_W-1:31];
		if (hi == '0 || hi == '1)
			return v[31:0];
		return v[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

endpackage

// ===== design/nrbf_ram.sv =====
module nrbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

endmodule

// ===== design/nrbf_exp_rom.sv =====
module nrbf_exp_rom #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	output logic [15:0]   data_q
);

	typedef logic [15:0] tbl_t [DEPTH];

	// exp(-16*n/DEPTH): Taylor ratio in Q0.32, then a truncated running product
	function automatic tbl_t build_tbl();
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] p;
		logic [63:0] e;
		tbl_t t;
		x    = (64'd16 << 32) / DEPTH;
		term = 64'd1 << 32;
		r    = term;
		p    = 64'd1 << 32;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x) >> 32) / 64'(n);
			if (n % 2 == 1)
				r = r - term;
			else
				r = r + term;
		end
		for (int n = 0; n < DEPTH; n++) begin
			e = (p + 64'd32768) >> 16;
			t[n] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
			p = (p * r) >> 32;
		end
		return t;
	endfunction

	localparam tbl_t TBL = build_tbl();

	always_ff @(posedge clk) begin
		data_q <= TBL[addr];
	end

endmodule

// ===== design/nrbf_div.sv =====
module nrbf_div #(
	parameter int TOTW = 22
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [TOTW-1:0] divisor,
	output logic            done_q,
	output logic [32:0]     quot_q
);

	// floor(2^32 / divisor), one quotient bit per cycle
	logic            busy_q;
	logic [5:0]      cnt_q;
	logic [TOTW-1:0] dvs_q;
	logic [TOTW-1:0] rem_q;
	logic [TOTW:0]   sh;
	logic            fits;

	assign sh   = {rem_q, cnt_q == 6'd33};
	assign fits = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && cnt_q == 6'd1;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? TOTW'(sh - {1'b0, dvs_q}) : sh[TOTW-1:0];
			quot_q <= {quot_q[31:0], fits};
		end
	end

endmodule

// ===== design/nrbf_mul.sv =====
module nrbf_mul (
	input  logic                                clk,
	input  logic signed [nrbf_pkg::MUL_W-1:0]   a,
	input  logic signed [nrbf_pkg::MUL_W-1:0]   b,
	output logic signed [nrbf_pkg::PROD_W-1:0]  prod_q
);
	import nrbf_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ===== design/normalized_rbf_td_learner_core.sv =====
// Normalized Gaussian RBF approximator with eligibility-trace learning.
// Input channel (in_valid/in_stall): one transaction carries action, coord_0/1
// and error_0/1. Evaluate and update each give one output transaction
// (out_valid/out_stall); both clear actions give none.
// All multiplications run through one registered 34x34 multiplier under a sequencer,
// so the block holds in_stall high while an item is in flight.
// Steps per item, N = GRID_0*GRID_1 centers:
//   evaluate  feature pass over all N centers, divider wait, normalize pass
//   update    feature pass, divider wait, second pass: normalize, trace and weight rewrite
//   no coverage: feature pass only; clear actions: N entries (one entry per cycle).
// The multiplier is used in most steps of each pass and sets the pace.
// The result sits in an output register: the next item is taken while it waits;
// a finished item holds in its last state until the output register frees up.
// Reset: a clearing pass over all N entries zeroes weights and traces; in_stall is high
// meanwhile. Configuration writes (cfg_we/cfg_index/cfg_data) are taken any time
// and belong between items.
module normalized_rbf_td_learner_core #(
	parameter int GRID_0          = nrbf_pkg::GRID_0_DEF,
	parameter int GRID_1          = nrbf_pkg::GRID_1_DEF,
	parameter int OUT_DIMS        = nrbf_pkg::OUT_DIMS_DEF,
	parameter int EXP_TABLE_DEPTH = nrbf_pkg::EXP_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [nrbf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nrbf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           action,
	input  logic signed [15:0]                   coord_0,
	input  logic signed [15:0]                   coord_1,
	input  logic signed [31:0]                   error_0,
	input  logic signed [31:0]                   error_1,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [31:0]                   out_value_0,
	output logic signed [31:0]                   out_value_1,
	output logic                                 no_coverage
);
	import nrbf_pkg::*;

	localparam int NUM  = GRID_0 * GRID_1;
	localparam int KW   = $clog2(NUM);
	localparam int I0W  = $clog2(GRID_0);
	localparam int TOTW = 16 + $clog2(NUM);
	localparam int AW   = $clog2(EXP_TABLE_DEPTH);
	localparam int WW   = 32 * OUT_DIMS;

	typedef enum logic [24:0] {
		S_CLR  = 25'h0000001,
		S_IDLE = 25'h0000002,
		S_F_SQ0 = 25'h0000004,
		S_F_Q0 = 25'h0000008,
		S_F_SQ1 = 25'h0000010,
		S_F_Q1 = 25'h0000020,
		S_F_IDX = 25'h0000040,
		S_F_ROM = 25'h0000080,
		S_F_WR = 25'h0000100,
		S_DIV  = 25'h0000200,
		S_G0   = 25'h0000400,
		S_G1   = 25'h0000800,
		S_G2   = 25'h0001000,
		S_P_RD = 25'h0002000,
		S_P_N  = 25'h0004000,
		S_P_E  = 25'h0008000,
		S_P_C  = 25'h0010000,
		S_E_W0 = 25'h0020000,
		S_E_A0 = 25'h0040000,
		S_E_A1 = 25'h0080000,
		S_U_T  = 25'h0100000,
		S_U_TS = 25'h0200000,
		S_U_G0 = 25'h0400000,
		S_U_W0 = 25'h0800000,
		S_U_W1 = 25'h1000000
	} state_t;

	// configuration
	logic signed [15:0] low0_q, low1_q;
	logic [15:0]        step0_q, step1_q, inv0_q, inv1_q, learn_q, decay_q;

	// control
	state_t      state_q, state_nx;
	logic        done_q;
	logic [KW-1:0] k_q;
	logic        k_last, k_step;
	logic        hold_end, hold_q;
	logic        clr_w_q;
	logic        out_valid_q;
	logic        out_free;
	logic        in_acc;

	// per-item payload
	action_t             act_q;
	logic signed [15:0]  c0_q, c1_q;
	logic signed [31:0]  err0_q, err1_q;
	logic [I0W-1:0]      i0_q;
	logic signed [CEN_W-1:0] cen0_q, cen1_q;
	logic [29:0]         q0_q;
	logic                zero_q;
	logic [TOTW-1:0]     total_q;
	logic [32:0]         recip_q;
	logic                nocov_q;
	logic signed [31:0]  g0_q, g1_q;
	logic [31:0]         n_q;
	logic [16:0]         phe_q, phi_q;
	logic signed [63:0]  acc0_q, acc1_q;
	logic [31:0]         tnew_q;
	logic signed [31:0]  w0new_q;
	logic signed [31:0]  out0_q, out1_q;
	logic                nocov_out_q;

	// datapath
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [CEN_W-1:0]  d0, d1;
	logic [14:0]              mag0, mag1;
	logic [29:0]              qc;
	logic [30:0]              qsum;
	logic [AW-1:0]            rom_addr;
	logic [15:0]              rom_data;
	logic [15:0]              feat;
	logic [TOTW-1:0]          total_nx;
	logic [16:0]              phe;
	logic [32:0]              t_sum;
	logic [31:0]              tsat;
	logic signed [31:0]       w0_rd, w1_rd, w0new, w1new;
	logic                     div_start, div_done;
	logic [32:0]              div_quot;

	logic [15:0]  scr_rd;
	logic [31:0]  tr_rd;
	logic [WW-1:0] wt_rd;
	logic          wt_we, tr_we;
	logic [WW-1:0] wt_wdata;
	logic [31:0]   tr_wdata;

	assign in_stall    = state_q != S_IDLE;
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign out_value_0 = out0_q;
	assign out_value_1 = out1_q;
	assign no_coverage = nocov_out_q;
	assign out_free    = !out_valid_q || !out_stall;
	assign k_last      = k_q == KW'(NUM - 1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low0_q  <= '0;
			low1_q  <= '0;
			step0_q <= 16'd256;
			step1_q <= 16'd256;
			inv0_q  <= 16'd256;
			inv1_q  <= 16'd256;
			learn_q <= '0;
			decay_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_0:       low0_q  <= cfg_data;
				REG_LOW_1:       low1_q  <= cfg_data;
				REG_STEP_0:      step0_q <= cfg_data;
				REG_STEP_1:      step1_q <= cfg_data;
				REG_INV_VAR_0:   inv0_q  <= cfg_data;
				REG_INV_VAR_1:   inv1_q  <= cfg_data;
				REG_LEARN_RATE:  learn_q <= cfg_data;
				REG_TRACE_DECAY: decay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// feature-pass arithmetic
	assign d0       = CEN_W'(c0_q) - cen0_q;
	assign d1       = CEN_W'(c1_q) - cen1_q;
	assign mag0     = mag15(d0);
	assign mag1     = mag15(d1);
	assign qc       = clamp_q(prod);
	assign qsum     = {1'b0, q0_q} + {1'b0, qc};
	assign rom_addr = prod[29+AW-1:29];
	assign feat     = zero_q ? 16'd0 : rom_data;
	assign total_nx = total_q + TOTW'(feat);

	// second-pass arithmetic
	assign phe   = prod[48:32];
	assign t_sum = {1'b0, prod[47:16]} + {16'd0, phi_q};
	assign tsat  = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
	assign w0_rd = $signed(wt_rd[31:0]);
	assign w1_rd = $signed(wt_rd[WW-1 -: 32]);
	assign w0new = sat32(PROD_W'(w0_rd) + (prod >>> 16));
	assign w1new = sat32(PROD_W'(w1_rd) + (prod >>> 16));

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_F_SQ0: begin
				mul_a = MUL_W'(mag0);
				mul_b = MUL_W'(mag0);
			end
			S_F_Q0: begin
				mul_a = MUL_W'(qc);
				mul_b = MUL_W'(inv0_q);
			end
			S_F_SQ1: begin
				mul_a = MUL_W'(mag1);
				mul_b = MUL_W'(mag1);
			end
			S_F_Q1: begin
				mul_a = MUL_W'(qc);
				mul_b = MUL_W'(inv1_q);
			end
			S_F_IDX: begin
				mul_a = MUL_W'(qsum[28:0]);
				mul_b = MUL_W'(EXP_TABLE_DEPTH);
			end
			S_G0: begin
				mul_a = MUL_W'(learn_q);
				mul_b = MUL_W'(err0_q);
			end
			S_G1: begin
				mul_a = MUL_W'(learn_q);
				mul_b = MUL_W'(err1_q);
			end
			S_P_N: begin
				mul_a = MUL_W'({scr_rd, 16'd0});
				mul_b = MUL_W'(recip_q);
			end
			S_P_E: begin
				mul_a = MUL_W'({1'b0, phe} + 18'd1);
				mul_b = MUL_W'(total_q);
			end
			S_E_W0: begin
				mul_a = MUL_W'(w0_rd);
				mul_b = MUL_W'(phi_q);
			end
			S_E_A0: begin
				// single column: leave the product at zero so a held last center adds once
				if (OUT_DIMS > 1) begin
					mul_a = MUL_W'(w1_rd);
					mul_b = MUL_W'(phi_q);
				end
			end
			S_U_T: begin
				mul_a = MUL_W'(tr_rd);
				mul_b = MUL_W'(decay_q);
			end
			S_U_G0: begin
				mul_a = MUL_W'(g0_q);
				mul_b = MUL_W'(tnew_q);
			end
			S_U_W0: begin
				mul_a = MUL_W'(g1_q);
				mul_b = MUL_W'(tnew_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_comb begin
		state_nx  = state_q;
		k_step    = 1'b0;
		div_start = 1'b0;
		hold_end  = 1'b0;
		unique case (state_q)
			S_CLR: begin
				k_step = 1'b1;
				if (k_last)
					state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					if (action == ACT_CLR_ALL || action == ACT_CLR_TRACE)
						state_nx = S_CLR;
					else
						state_nx = S_F_SQ0;
				end
			end
			S_F_SQ0: state_nx = S_F_Q0;
			S_F_Q0:  state_nx = S_F_SQ1;
			S_F_SQ1: state_nx = S_F_Q1;
			S_F_Q1:  state_nx = S_F_IDX;
			S_F_IDX: state_nx = S_F_ROM;
			S_F_ROM: state_nx = S_F_WR;
			S_F_WR: begin
				k_step = 1'b1;
				if (!k_last)
					state_nx = S_F_SQ0;
				else if (total_nx == '0)
					state_nx = S_G2;
				else begin
					div_start = 1'b1;
					state_nx  = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done)
					state_nx = S_G0;
			end
			S_G0: state_nx = S_G1;
			S_G1: state_nx = S_G2;
			S_G2: begin
				// no coverage: skip the second pass entirely
				if (nocov_q) begin
					if (out_free)
						state_nx = S_IDLE;
				end else
					state_nx = S_P_RD;
			end
			S_P_RD: state_nx = S_P_N;
			S_P_N:  state_nx = S_P_E;
			S_P_E:  state_nx = S_P_C;
			S_P_C:  state_nx = (act_q == ACT_EVAL) ? S_E_W0 : S_U_T;
			S_E_W0: state_nx = S_E_A0;
			S_E_A0: begin
				if (OUT_DIMS > 1)
					state_nx = S_E_A1;
				else begin
					k_step   = 1'b1;
					state_nx = S_P_RD;
				end
			end
			S_E_A1: begin
				k_step   = 1'b1;
				state_nx = S_P_RD;
			end
			S_U_T:  state_nx = S_U_TS;
			S_U_TS: state_nx = S_U_G0;
			S_U_G0: state_nx = S_U_W0;
			S_U_W0: begin
				if (OUT_DIMS > 1)
					state_nx = S_U_W1;
				else begin
					k_step   = 1'b1;
					state_nx = S_P_RD;
				end
			end
			S_U_W1: begin
				k_step   = 1'b1;
				state_nx = S_P_RD;
			end
			default: state_nx = S_IDLE;
		endcase
		// end of the second pass: hold at the last center until the result can go out
		if (k_step && k_last && state_q != S_CLR && state_q != S_F_WR) begin
			if (out_free)
				state_nx = S_IDLE;
			else begin
				state_nx = state_q;
				k_step   = 1'b0;
				hold_end = 1'b1;
			end
		end
	end

	// a result leaves the sequencer in this cycle
	assign done_q = (state_q == S_G2 && nocov_q && out_free)
		|| (k_step && k_last && state_q != S_CLR && state_q != S_F_WR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			k_q         <= '0;
			clr_w_q     <= 1'b1;
			out_valid_q <= 1'b0;
			hold_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			hold_q  <= hold_end;
			if (in_acc) begin
				k_q     <= '0;
				clr_w_q <= action == ACT_CLR_ALL;
			end else if (k_step)
				k_q <= k_last ? '0 : k_q + KW'(1);
			if (done_q)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q   <= action_t'(action);
			c0_q    <= coord_0;
			c1_q    <= coord_1;
			err0_q  <= error_0;
			err1_q  <= error_1;
			i0_q    <= '0;
			cen0_q  <= CEN_W'(low0_q);
			cen1_q  <= CEN_W'(low1_q);
			total_q <= '0;
			nocov_q <= 1'b0;
			acc0_q  <= '0;
			acc1_q  <= '0;
		end
		if (state_q == S_F_SQ1)
			q0_q <= qc;
		if (state_q == S_F_IDX)
			zero_q <= qsum >= {1'b0, Q_LIMIT};
		if (state_q == S_F_WR) begin
			total_q <= total_nx;
			if (k_last)
				nocov_q <= total_nx == '0;
			if (i0_q == I0W'(GRID_0 - 1)) begin
				i0_q   <= '0;
				cen0_q <= CEN_W'(low0_q);
				cen1_q <= cen1_q + CEN_W'($signed({1'b0, step1_q}));
			end else begin
				i0_q   <= i0_q + I0W'(1);
				cen0_q <= cen0_q + CEN_W'($signed({1'b0, step0_q}));
			end
		end
		if (state_q == S_DIV && div_done)
			recip_q <= div_quot;
		if (state_q == S_G1)
			g0_q <= $signed(prod[47:16]);
		if (state_q == S_G2)
			g1_q <= $signed(prod[47:16]);
		if (state_q == S_P_N)
			n_q <= {scr_rd, 16'd0};
		if (state_q == S_P_E)
			phe_q <= phe;
		if (state_q == S_P_C)
			phi_q <= (prod <= $signed({{(PROD_W-32){1'b0}}, n_q})) ? phe_q + 17'd1 : phe_q;
		if (state_q == S_E_A0 && !(done_q && OUT_DIMS == 1))
			acc0_q <= acc0_q + $signed(prod[63:0]);
		if (state_q == S_E_A1 && !done_q)
			acc1_q <= acc1_q + $signed(prod[63:0]);
		if (state_q == S_U_TS)
			tnew_q <= tsat;
		if (state_q == S_U_W0)
			w0new_q <= w0new;
		if (done_q) begin
			nocov_out_q <= nocov_q;
			out0_q      <= '0;
			out1_q      <= '0;
			if (act_q == ACT_EVAL && !nocov_q) begin
				// last center's product for the final column is folded in here
				if (OUT_DIMS > 1) begin
					out0_q <= sat32(PROD_W'(acc0_q >>> 16));
					out1_q <= sat32(PROD_W'((acc1_q + $signed(prod[63:0])) >>> 16));
				end else
					out0_q <= sat32(PROD_W'((acc0_q + $signed(prod[63:0])) >>> 16));
			end
		end
	end

	// memory write data; a held last center is written only in its first cycle
	assign tr_we    = state_q == S_CLR || state_q == S_U_TS;
	assign tr_wdata = (state_q == S_CLR) ? 32'd0 : tsat;
	assign wt_we    = (state_q == S_CLR && clr_w_q)
		|| ((state_q == S_U_W1 || (state_q == S_U_W0 && OUT_DIMS == 1)) && !hold_q);

	always_comb begin
		wt_wdata = '0;
		if (state_q != S_CLR) begin
			wt_wdata[31:0] = (OUT_DIMS > 1) ? w0new_q : w0new;
			if (OUT_DIMS > 1)
				wt_wdata[WW-1 -: 32] = w1new;
		end
	end

	nrbf_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	nrbf_div #(.TOTW(TOTW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (total_nx),
		.done_q  (div_done),
		.quot_q  (div_quot)
	);

	nrbf_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_exp (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_data)
	);

	nrbf_ram #(.WIDTH(16), .DEPTH(NUM)) u_scratch (
		.clk     (clk),
		.we      (state_q == S_F_WR),
		.waddr   (k_q),
		.wdata   (feat),
		.re      (state_q == S_P_RD),
		.raddr   (k_q),
		.rdata_q (scr_rd)
	);

	nrbf_ram #(.WIDTH(32), .DEPTH(NUM)) u_trace (
		.clk     (clk),
		.we      (tr_we),
		.waddr   (k_q),
		.wdata   (tr_wdata),
		.re      (state_q == S_P_RD),
		.raddr   (k_q),
		.rdata_q (tr_rd)
	);

	nrbf_ram #(.WIDTH(WW), .DEPTH(NUM)) u_weights (
		.clk     (clk),
		.we      (wt_we),
		.waddr   (k_q),
		.wdata   (wt_wdata),
		.re      (state_q == S_P_RD),
		.raddr   (k_q),
		.rdata_q (wt_rd)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input accepted while not idle afterwards");

	a_nocov_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_coverage) |-> (out_value_0 == 0 && out_value_1 == 0))
		else $error("no-coverage result with nonzero outputs");

	a_single_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (OUT_DIMS > 1 || out_value_1 == 0))
		else $error("unused output column is nonzero");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");
`endif

endmodule
